// ===== hw/rtl/rsort_pkg.sv =====
// Shared types, constants and codes for the record sort block.
package rsort_pkg;

  localparam int CAPACITY = 64;
  localparam int REC_W    = 61;
  localparam int KEY_W    = 2;

  localparam logic [KEY_W-1:0] KEY_ID    = 2'd0;
  localparam logic [KEY_W-1:0] KEY_GRADE = 2'd1;
  localparam logic [KEY_W-1:0] KEY_NAME  = 2'd2;

  typedef struct packed {
    logic [47:0] name;
    logic [2:0]  grade;
    logic [9:0]  id;
  } rec_t;

  typedef enum logic [1:0] {
    RSEL_I,
    RSEL_J,
    RSEL_K
  } rsel_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_I,
    ST_HOLD,
    ST_READ_J,
    ST_CMP,
    ST_WB,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic  load;
    logic  i_clr;
    logic  i_inc;
    logic  j_set;
    logic  j_inc;
    logic  k_clr;
    logic  k_inc;
    logic  hold_ld;
    logic  cmp;
    logic  wb;
    logic  out_ld;
    logic  cnt_clr;
    rsel_t rsel;
  } cmd_t;

  typedef struct packed {
    logic in_final;
    logic i_last;
    logic j_last;
    logic k_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/rsort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rsort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rsort_ctrl.sv =====
// Sequencer for load, exchange sort and emission phases.
module rsort_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  rsort_pkg::sts_t    sts,
  output rsort_pkg::cmd_t    cmd
);

  rsort_pkg::state_t state;
  rsort_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsort_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rsort_pkg::ST_LOAD: begin
        if (sts.in_final) state_next = rsort_pkg::ST_SORT_I;
      end
      rsort_pkg::ST_SORT_I: begin
        state_next = sts.i_last ? rsort_pkg::ST_EMIT_RD : rsort_pkg::ST_HOLD;
      end
      rsort_pkg::ST_HOLD:   state_next = rsort_pkg::ST_READ_J;
      rsort_pkg::ST_READ_J: state_next = rsort_pkg::ST_CMP;
      rsort_pkg::ST_CMP: begin
        state_next = sts.j_last ? rsort_pkg::ST_WB : rsort_pkg::ST_READ_J;
      end
      rsort_pkg::ST_WB:     state_next = rsort_pkg::ST_SORT_I;
      rsort_pkg::ST_EMIT_RD: begin
        if (sts.out_free) state_next = rsort_pkg::ST_EMIT_LD;
      end
      rsort_pkg::ST_EMIT_LD: begin
        state_next = sts.k_last ? rsort_pkg::ST_LOAD : rsort_pkg::ST_EMIT_RD;
      end
      default: state_next = rsort_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rsel = rsort_pkg::RSEL_I;
    unique case (state)
      rsort_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        cmd.i_clr = 1'b1;
        cmd.k_clr = 1'b1;
      end
      rsort_pkg::ST_SORT_I: cmd.rsel = rsort_pkg::RSEL_I;
      rsort_pkg::ST_HOLD: begin
        cmd.hold_ld = 1'b1;
        cmd.j_set   = 1'b1;
      end
      rsort_pkg::ST_READ_J: cmd.rsel = rsort_pkg::RSEL_J;
      rsort_pkg::ST_CMP: begin
        cmd.cmp   = 1'b1;
        cmd.j_inc = 1'b1;
      end
      rsort_pkg::ST_WB: begin
        cmd.wb    = 1'b1;
        cmd.i_inc = 1'b1;
      end
      rsort_pkg::ST_EMIT_RD: cmd.rsel = rsort_pkg::RSEL_K;
      rsort_pkg::ST_EMIT_LD: begin
        cmd.out_ld  = 1'b1;
        cmd.k_inc   = 1'b1;
        cmd.cnt_clr = sts.k_last;
      end
      default: cmd.rsel = rsort_pkg::RSEL_I;
    endcase
  end

endmodule

// ===== hw/rtl/rsort_dp.sv =====
// Datapath: record store, counters, held record, key compare and output register.
module rsort_dp #(
  parameter int CAPACITY = rsort_pkg::CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rsort_pkg::cmd_t             cmd,
  output rsort_pkg::sts_t             sts,
  input  logic                        cfg_valid,
  input  logic [rsort_pkg::KEY_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_last,
  input  rsort_pkg::rec_t             in_rec,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_last,
  output rsort_pkg::rec_t             out_rec
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [rsort_pkg::KEY_W-1:0] sort_key;
  logic [CW-1:0]               count;
  logic [AW-1:0]               i;
  logic [AW-1:0]               j;
  logic [AW-1:0]               k;
  rsort_pkg::rec_t             held;
  rsort_pkg::rec_t             rd_rec;
  logic [rsort_pkg::REC_W-1:0] rdata;
  logic                        in_fire;
  logic                        full;
  logic                        after;
  logic                        we;
  logic [AW-1:0]               waddr;
  rsort_pkg::rec_t             wdata;
  logic [AW-1:0]               raddr;

  assign in_fire = cmd.load & in_valid;
  assign full    = (count >= CW'(CAPACITY));
  assign rd_rec  = rsort_pkg::rec_t'(rdata);

  always_comb begin
    case (sort_key)
      rsort_pkg::KEY_GRADE: after = held.grade < rd_rec.grade;
      rsort_pkg::KEY_NAME:  after = held.name > rd_rec.name;
      default:              after = held.id > rd_rec.id;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = in_rec;
    if (in_fire && !full) begin
      we = 1'b1;
    end else if (cmd.cmp && after) begin
      we    = 1'b1;
      waddr = j;
      wdata = held;
    end else if (cmd.wb) begin
      we    = 1'b1;
      waddr = i;
      wdata = held;
    end
  end

  always_comb begin
    unique case (cmd.rsel)
      rsort_pkg::RSEL_J: raddr = j;
      rsort_pkg::RSEL_K: raddr = k;
      default:           raddr = i;
    endcase
  end

  rsort_ram #(
    .WIDTH (rsort_pkg::REC_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key  <= rsort_pkg::KEY_ID;
      count     <= '0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) sort_key <= cfg_data;
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (in_fire && !full) begin
        count <= count + CW'(1);
      end
      if (cmd.i_clr) begin
        i <= '0;
      end else if (cmd.i_inc) begin
        i <= i + AW'(1);
      end
      if (cmd.j_set) begin
        j <= i + AW'(1);
      end else if (cmd.j_inc) begin
        j <= j + AW'(1);
      end
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + AW'(1);
      end
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_ld) begin
      held <= rd_rec;
    end else if (cmd.cmp && after) begin
      held <= rd_rec;
    end
    if (cmd.out_ld) begin
      out_rec  <= rd_rec;
      out_last <= sts.k_last;
    end
  end

  assign sts.in_final = in_fire & in_last;
  assign sts.i_last   = ({1'b0, i} + (AW + 1)'(1)) >= (AW + 1)'(count);
  assign sts.j_last   = ({1'b0, j} + (AW + 1)'(1)) == (AW + 1)'(count);
  assign sts.k_last   = ({1'b0, k} + (AW + 1)'(1)) == (AW + 1)'(count);
  assign sts.out_free = ~out_valid | out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("record count beyond capacity");

  a_j_above_i: assert property (@(posedge clk) disable iff (rst)
    cmd.cmp |-> (j > i))
    else $error("compare index not above held index");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_clr |=> (count == '0))
    else $error("record count not cleared after emission");

endmodule

// ===== hw/rtl/record_sort_by_selected_key_core.sv =====
// Top level of the record sort block: stream ports, configuration port, controller and datapath.
//
// Records are taken one per cycle until a word with tlast; a record arriving while CAPACITY
// records are held is dropped, though its tlast still closes the set. The set of n records is
// then exchange sorted through a single-port-read record RAM: each outer pass holds record i
// and reads each later record in turn, swapping when the held record sorts later, then writes
// the held record back to i. The sorted records then leave one at a time, the last with tlast,
// and the input reopens after the final one is loaded into the output register. The sort key
// is written on the cfg port: 0 id ascending, 1 grade descending, 2 name ascending, 3 as 0.
module record_sort_by_selected_key_core #(
  parameter int CAPACITY = rsort_pkg::CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rsort_pkg::KEY_W-1:0] cfg_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,  // rec_id[9:0], grade[12:10], student_name[60:13]
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,  // out_id[9:0], out_grade[12:10], out_name[60:13]
  output logic                        m_axis_tlast
);

  rsort_pkg::cmd_t cmd;
  rsort_pkg::sts_t sts;
  rsort_pkg::rec_t out_rec;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = cmd.load;
  assign m_axis_tdata  = {3'b000, out_rec};

  rsort_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rsort_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_rec    (rsort_pkg::rec_t'(s_axis_tdata[rsort_pkg::REC_W-1:0])),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_last  (m_axis_tlast),
    .out_rec   (out_rec)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the record sort core: directed table, random sets and key changes.
module testbench;

  localparam logic [rsort_pkg::KEY_W-1:0] KEY_SPARE = 2'd3;
  localparam int LIMIT = 400000;
  localparam int SETTLE = 16;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic                        wr_key;
    logic [rsort_pkg::KEY_W-1:0] key;
    rsort_pkg::rec_t             rec;
    logic                        fin;
    logic                        typed;
  } row_t;

  typedef struct {
    rsort_pkg::rec_t rec;
    logic            last;
  } sorted_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [rsort_pkg::KEY_W-1:0] cfg_data = rsort_pkg::KEY_ID;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [63:0]                 s_axis_tdata = '0;
  logic                        s_axis_tlast = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [63:0]                 m_axis_tdata;
  logic                        m_axis_tlast;

  rsort_pkg::rec_t             held_recs[$];
  sorted_t                     sorted_q[$];
  logic [rsort_pkg::KEY_W-1:0] key_now = rsort_pkg::KEY_ID;
  int                          errors = 0;
  int                          cycles = 0;
  bit                          tx_calm = 1'b0;
  bit                          rx_calm = 1'b0;

  record_sort_by_selected_key_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (errors < MAX_PRINTS) begin
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    end
    errors++;
  endtask

  function automatic row_t mk(logic wr, logic [rsort_pkg::KEY_W-1:0] k, logic [9:0] id,
                              logic [2:0] g, logic [47:0] nm, logic fin, logic typed);
    row_t r;
    r.wr_key    = wr;
    r.key       = k;
    r.rec.id    = id;
    r.rec.grade = g;
    r.rec.name  = nm;
    r.fin       = fin;
    r.typed     = typed;
    return r;
  endfunction

  function automatic bit goes_later(rsort_pkg::rec_t a, rsort_pkg::rec_t b,
                                    logic [rsort_pkg::KEY_W-1:0] k);
    case (k)
      rsort_pkg::KEY_GRADE: return a.grade < b.grade;
      rsort_pkg::KEY_NAME:  return a.name > b.name;
      default:              return a.id > b.id;
    endcase
  endfunction

  task automatic sort_held_set();
    rsort_pkg::rec_t t;
    sorted_t         s;
    for (int i = 0; i < held_recs.size(); i++) begin
      for (int j = i + 1; j < held_recs.size(); j++) begin
        if (goes_later(held_recs[i], held_recs[j], key_now)) begin
          t            = held_recs[i];
          held_recs[i] = held_recs[j];
          held_recs[j] = t;
        end
      end
    end
    foreach (held_recs[n]) begin
      s.rec  = held_recs[n];
      s.last = (n == held_recs.size() - 1);
      sorted_q.push_back(s);
    end
    held_recs.delete();
  endtask

  task automatic take_record(rsort_pkg::rec_t r, logic fin, logic typed);
    sorted_t s;
    if (typed) begin
      s.rec  = r;
      s.last = 1'b1;
      sorted_q.push_back(s);
      held_recs.delete();
    end else begin
      if (held_recs.size() < rsort_pkg::CAPACITY) held_recs.push_back(r);
      if (fin) sort_held_set();
    end
  endtask

  task automatic offer_record(rsort_pkg::rec_t r, logic fin, logic typed);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, r};
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    take_record(r, fin, typed);
  endtask

  task automatic load_sort_key(logic [rsort_pkg::KEY_W-1:0] k);
    s_axis_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_now = k;
  endtask

  function automatic rsort_pkg::rec_t random_record(bit crowded);
    rsort_pkg::rec_t r;
    int              len;
    logic [47:0]     nm;
    r.id    = crowded ? 10'($urandom_range(0, 7)) : 10'($urandom_range(0, 1023));
    r.grade = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 5));
    nm = '0;
    if (!crowded && $urandom_range(0, 7) == 0) begin
      nm = 48'({$urandom(), $urandom()});
    end else begin
      len = crowded ? $urandom_range(1, 2) : $urandom_range(0, 6);
      for (int b = 0; b < len; b++) begin
        nm[47-8*b -: 8] = crowded ? 8'($urandom_range(65, 67))
                        : 8'((($urandom_range(0, 1) != 0) ? 65 : 97) + $urandom_range(0, 25));
      end
    end
    r.name = nm;
    return r;
  endfunction

  initial begin
    int stall;
    forever begin
      if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && !rst));
    end
  end

  always @(posedge clk) begin
    sorted_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sorted_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, '0);
      end else begin
        want = sorted_q.pop_front();
        if (m_axis_tdata[9:0] !== want.rec.id)
          report_mismatch("out_id", 64'(m_axis_tdata[9:0]), 64'(want.rec.id));
        if (m_axis_tdata[12:10] !== want.rec.grade)
          report_mismatch("out_grade", 64'(m_axis_tdata[12:10]), 64'(want.rec.grade));
        if (m_axis_tdata[60:13] !== want.rec.name)
          report_mismatch("out_name", 64'(m_axis_tdata[60:13]), 64'(want.rec.name));
        if (m_axis_tlast !== want.last)
          report_mismatch("out_last", 64'(m_axis_tlast), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int               sets;
    int               done_items;
    int               size;
    bit               crowded;
    row_t             plan[0:21];
    plan = '{
      mk(1'b1, rsort_pkg::KEY_ID,    10'd0,    3'd1, 48'h000000000000, 1'b1, 1'b1),
      mk(1'b0, rsort_pkg::KEY_ID,    10'd1023, 3'd7, 48'hFFFFFFFFFFFF, 1'b1, 1'b1),
      mk(1'b0, rsort_pkg::KEY_ID,    10'd500,  3'd3, 48'h424F42000000, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_ID,    10'd3,    3'd5, 48'h414C49434500, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_ID,    10'd1023, 3'd2, 48'h000000000000, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_ID,    10'd3,    3'd4, 48'h5A5A5A5A5A5A, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_ID,    10'd0,    3'd1, 48'h424F42425900, 1'b1, 1'b0),
      mk(1'b1, rsort_pkg::KEY_GRADE, 10'd10,   3'd5, 48'h44414E000000, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_GRADE, 10'd11,   3'd0, 48'h455645000000, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_GRADE, 10'd12,   3'd7, 48'h464159000000, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_GRADE, 10'd13,   3'd6, 48'h475553000000, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_GRADE, 10'd14,   3'd1, 48'h48414C000000, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_GRADE, 10'd15,   3'd5, 48'h495659000000, 1'b1, 1'b0),
      mk(1'b1, rsort_pkg::KEY_NAME,  10'd20,   3'd3, 48'h424F42000000, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_NAME,  10'd21,   3'd3, 48'h424F42425900, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_NAME,  10'd22,   3'd3, 48'h414C49434500, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_NAME,  10'd23,   3'd3, 48'h5A5A5A5A5A5A, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_NAME,  10'd24,   3'd3, 48'h000000000000, 1'b0, 1'b0),
      mk(1'b0, rsort_pkg::KEY_NAME,  10'd25,   3'd3, 48'h424F42000000, 1'b1, 1'b0),
      mk(1'b1, KEY_SPARE,            10'd9,    3'd2, 48'h580000000000, 1'b0, 1'b0),
      mk(1'b0, KEY_SPARE,            10'd2,    3'd2, 48'h590000000000, 1'b0, 1'b0),
      mk(1'b0, KEY_SPARE,            10'd5,    3'd2, 48'h5A0000000000, 1'b1, 1'b0)
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[n]) begin
      if (plan[n].wr_key) load_sort_key(plan[n].key);
      offer_record(plan[n].rec, plan[n].fin, plan[n].typed);
    end
    sets       = 0;
    done_items = 0;
    while (done_items < 250) begin
      if (sets == 0 || $urandom_range(0, 2) == 0) load_sort_key(2'($urandom_range(0, 3)));
      tx_calm = ($urandom_range(0, 3) == 0);
      crowded = ($urandom_range(0, 3) == 0);
      if (sets == 1) size = rsort_pkg::CAPACITY;
      else if (sets == 5) size = rsort_pkg::CAPACITY + $urandom_range(1, 3);
      else size = $urandom_range(1, 12);
      for (int n = 0; n < size; n++) begin
        offer_record(random_record(crowded), n == size - 1, 1'b0);
      end
      done_items += size;
      sets++;
    end
    s_axis_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
